// File: sv/sync_framed_sample_deframer_assert.svh
// ----------------------------------------------------------------------------
// sync_framed_sample_deframer_assert.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_SAMPLE_DEFRAMER_ASSERT_SVH
`define SYNC_FRAMED_SAMPLE_DEFRAMER_ASSERT_SVH

// Property that must hold whenever reset is released.
`define SFSD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deframer assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SFSD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// File: sv/sfsd_pkg.sv
// ----------------------------------------------------------------------------
// sfsd_pkg
// Types and constants of the sync framed sample deframer.
// ----------------------------------------------------------------------------
package sfsd_pkg;

    // Frame tracking phase; codes 5 to 7 are unused
    typedef enum logic [2:0] {
        PHASE_OOF = 3'd0,
        PHASE_PRE = 3'd1,
        PHASE_HDR = 3'd2,
        PHASE_MSB = 3'd3,
        PHASE_LSB = 3'd4
    } phase_t;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_WARN   = 1'b1;

    // One result transaction
    typedef struct packed {
        logic       kind;
        logic [3:0] channel_count;
        logic [8:0] channel;
        logic [9:0] sample_value;
    } result_t;

endpackage

// File: sv/sfsd_decode.sv
// ----------------------------------------------------------------------------
// sfsd_decode
// Frame state machine: sync hunt, header capture and MSB/LSB pair decode.
// ----------------------------------------------------------------------------
module sfsd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          byte_data,
    output logic                emit,
    output sfsd_pkg::result_t   result
);

    sfsd_pkg::phase_t phase_reg;
    sfsd_pkg::phase_t phase_next;
    logic [7:0]       header_reg;
    logic [7:0]       header_next;
    logic [7:0]       high_reg;
    logic [7:0]       high_next;
    logic             is_sync;

    assign is_sync = (byte_data == sfsd_pkg::SYNC_BYTE);

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        high_next   = high_reg;
        unique case (phase_reg)
            sfsd_pkg::PHASE_OOF:
            begin
                if (is_sync)
                begin
                    phase_next = sfsd_pkg::PHASE_PRE;
                end
            end
            sfsd_pkg::PHASE_PRE:
            begin
                phase_next = is_sync ? sfsd_pkg::PHASE_HDR : sfsd_pkg::PHASE_OOF;
            end
            sfsd_pkg::PHASE_HDR:
            begin
                // a sync byte here is stored but the header wait goes on
                header_next = byte_data;
                if (!is_sync)
                begin
                    phase_next = sfsd_pkg::PHASE_MSB;
                end
            end
            sfsd_pkg::PHASE_MSB:
            begin
                if (is_sync)
                begin
                    phase_next = sfsd_pkg::PHASE_PRE;
                end
                else
                begin
                    high_next  = byte_data;
                    phase_next = sfsd_pkg::PHASE_LSB;
                end
            end
            sfsd_pkg::PHASE_LSB:
            begin
                phase_next = sfsd_pkg::PHASE_MSB;
            end
            default:
            begin
                phase_next = sfsd_pkg::PHASE_OOF;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        emit   = 1'b0;
        result = '0;
        unique case (phase_reg)
            sfsd_pkg::PHASE_PRE:
            begin
                // failed second sync byte: warning with zero fields
                if (!is_sync)
                begin
                    emit        = 1'b1;
                    result.kind = sfsd_pkg::KIND_WARN;
                end
            end
            sfsd_pkg::PHASE_LSB:
            begin
                // channel = word[14:10] + offset * 32, value = word[9:0]
                emit                 = 1'b1;
                result.kind          = sfsd_pkg::KIND_SAMPLE;
                result.channel_count = header_reg[7:4];
                result.channel       = {header_reg[3:0], high_reg[6:2]};
                result.sample_value  = {high_reg[1:0], byte_data};
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sfsd_pkg::PHASE_OOF;
            header_reg <= '0;
            high_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            high_reg   <= high_next;
        end
    end

endmodule

// File: sv/sfsd_out_reg.sv
// ----------------------------------------------------------------------------
// sfsd_out_reg
// Result register; frees itself in the same cycle its transaction is taken.
// ----------------------------------------------------------------------------
module sfsd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sfsd_pkg::result_t   load_data,
    input  logic                stall,
    output logic                free,
    output logic                valid,
    output sfsd_pkg::result_t   data
);

    logic              valid_reg;
    logic              valid_next;
    sfsd_pkg::result_t data_reg;

    assign free       = !valid_reg || !stall;
    assign valid_next = load || (valid_reg && stall);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// File: sv/sync_framed_sample_deframer.sv
// ----------------------------------------------------------------------------
// sync_framed_sample_deframer
// Path: each accepted byte is registered in the byte register, and a result
// that it produces is then registered in the result register.
// Throughput: one byte per cycle; the byte register stalls only while a
// result-producing byte waits behind a stalled result register.
// Reset: asynchronous, active low; returns the frame state to out of frame.
// ----------------------------------------------------------------------------
module sync_framed_sample_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] byte_in,
    output logic       sample_valid,
    input  logic       sample_stall,
    output logic       kind,
    output logic [3:0] channel_count,
    output logic [8:0] channel,
    output logic [9:0] sample_value
);

    logic              byte_vld_reg;
    logic              byte_vld_next;
    logic [7:0]        byte_reg;
    logic              accept;
    logic              advance;
    logic              emit;
    logic              out_free;
    sfsd_pkg::result_t dec_result;
    sfsd_pkg::result_t out_data;

    // Byte register handshake
    assign advance       = byte_vld_reg && (!emit || out_free);
    assign byte_stall    = byte_vld_reg && !advance;
    assign accept        = byte_valid && !byte_stall;
    assign byte_vld_next = accept || (byte_vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in;
        end
    end

    // Frame decode
    sfsd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .byte_data (byte_reg),
        .emit      (emit),
        .result    (dec_result)
    );

    // Result register
    sfsd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .load_data (dec_result),
        .stall     (sample_stall),
        .free      (out_free),
        .valid     (sample_valid),
        .data      (out_data)
    );

    assign kind          = out_data.kind;
    assign channel_count = out_data.channel_count;
    assign channel       = out_data.channel;
    assign sample_value  = out_data.sample_value;

endmodule

// File: sv/sfsd_checker.sv
// ----------------------------------------------------------------------------
// sfsd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sync_framed_sample_deframer_assert.svh"

module sfsd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic       sample_valid,
    input  logic       sample_stall,
    input  logic       kind,
    input  logic [3:0] channel_count,
    input  logic [8:0] channel,
    input  logic [9:0] sample_value
);

    // A stalled result transaction holds
    `SFSD_ASSERT_NEXT(a_result_hold, clk, rst_n, sample_valid && sample_stall, sample_valid && $stable(kind) && $stable(channel_count) && $stable(channel) && $stable(sample_value))

    // Input stalls only behind a blocked result register
    `SFSD_ASSERT(a_stall_cause, clk, rst_n, !byte_stall || (sample_valid && sample_stall))

    // A warning carries zero fields
    `SFSD_ASSERT(a_warn_zero, clk, rst_n, !(sample_valid && kind) || (channel_count == 4'd0 && channel == 9'd0 && sample_value == 10'd0))

    // A fresh result can only follow a byte accepted on the input channel
    `SFSD_ASSERT(a_result_latency, clk, rst_n, !$rose(sample_valid) || $past(byte_valid && !byte_stall, 2))

endmodule

bind sync_framed_sample_deframer sfsd_checker u_sfsd_checker (.*);

// File: dv/deframer_checker.sv
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte and sample channels of the deframer. Each accepted byte
// runs through a local frame decoder, and each decoded sample or warning is
// queued. Each accepted result transaction is compared field by field with
// the oldest queued result. Mismatch and queue counts go to the top level.
// ----------------------------------------------------------------------------
module deframer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] byte_in,
    input  logic       sample_valid,
    input  logic       sample_stall,
    input  logic       kind,
    input  logic [3:0] channel_count,
    input  logic [8:0] channel,
    input  logic [9:0] sample_value,
    output int         errors,
    output int         pending
);

    // Decoder state
    sfsd_pkg::phase_t phase    = sfsd_pkg::PHASE_OOF;
    logic [7:0]       hdr_reg  = '0;
    logic [7:0]       msb_reg  = '0;

    // Decoded results not yet seen on the sample channel
    sfsd_pkg::result_t decoded_q[$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    // Advance the decoder by one byte; returns 1 when a result is produced
    function automatic bit decode_byte(input logic [7:0] b,
                                       output sfsd_pkg::result_t res);
        logic [15:0] word;
        bit          hit;
        hit = 1'b0;
        res = '0;
        case (phase)
            sfsd_pkg::PHASE_OOF: begin
                if (b == sfsd_pkg::SYNC_BYTE)
                    phase = sfsd_pkg::PHASE_PRE;
            end
            sfsd_pkg::PHASE_PRE: begin
                if (b == sfsd_pkg::SYNC_BYTE) begin
                    phase = sfsd_pkg::PHASE_HDR;
                end
                else begin
                    // false second sync byte: warning, other fields zero
                    phase    = sfsd_pkg::PHASE_OOF;
                    res.kind = sfsd_pkg::KIND_WARN;
                    hit      = 1'b1;
                end
            end
            sfsd_pkg::PHASE_HDR: begin
                // header is stored even when it repeats the sync byte
                hdr_reg = b;
                if (b != sfsd_pkg::SYNC_BYTE)
                    phase = sfsd_pkg::PHASE_MSB;
            end
            sfsd_pkg::PHASE_MSB: begin
                if (b == sfsd_pkg::SYNC_BYTE) begin
                    phase = sfsd_pkg::PHASE_PRE;
                end
                else begin
                    msb_reg = b;
                    phase   = sfsd_pkg::PHASE_LSB;
                end
            end
            sfsd_pkg::PHASE_LSB: begin
                word              = {msb_reg, b};
                res.kind          = sfsd_pkg::KIND_SAMPLE;
                res.channel_count = hdr_reg[7:4];
                res.channel       = {hdr_reg[3:0], word[14:10]};
                res.sample_value  = word[9:0];
                hit               = 1'b1;
                phase             = sfsd_pkg::PHASE_MSB;
            end
            default: begin
                phase = sfsd_pkg::PHASE_OOF;
            end
        endcase
        return hit;
    endfunction

    // Per-cycle prediction and comparison
    always @(posedge clk or negedge rst_n) begin
        sfsd_pkg::result_t want;
        sfsd_pkg::result_t made;
        int                bad;
        bad = 0;
        if (!rst_n) begin
            phase   = sfsd_pkg::PHASE_OOF;
            hdr_reg = '0;
            msb_reg = '0;
            decoded_q.delete();
        end
        else begin
            // result channel
            if (sample_valid && !sample_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d count %0d channel %0d value %0d",
                             $time, kind, channel_count, channel, sample_value);
                    bad++;
                end
                else begin
                    want = decoded_q.pop_front();
                    if (kind !== want.kind) begin
                        $display("%0t: kind mismatch: expected %0d actual %0d",
                                 $time, want.kind, kind);
                        bad++;
                    end
                    if (channel_count !== want.channel_count) begin
                        $display("%0t: channel_count mismatch: expected %0d actual %0d",
                                 $time, want.channel_count, channel_count);
                        bad++;
                    end
                    if (channel !== want.channel) begin
                        $display("%0t: channel mismatch: expected %0d actual %0d",
                                 $time, want.channel, channel);
                        bad++;
                    end
                    if (sample_value !== want.sample_value) begin
                        $display("%0t: sample_value mismatch: expected %0d actual %0d",
                                 $time, want.sample_value, sample_value);
                        bad++;
                    end
                end
            end
            // byte channel
            if (byte_valid && !byte_stall) begin
                if (decode_byte(byte_in, made))
                    decoded_q.push_back(made);
            end
        end
        errors  <= errors + bad;
        pending <= decoded_q.size();
    end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top level for the sync framed sample deframer. Drives a directed byte
// stream over the framing corner cases, then random frames mixed with noise
// and broken sync, with random idle bursts on both channels. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       byte_valid   = 1'b0;
    logic       byte_stall;
    logic [7:0] byte_in      = '0;
    logic       sample_valid;
    logic       sample_stall = 1'b0;
    logic       kind;
    logic [3:0] channel_count;
    logic [8:0] channel;
    logic [9:0] sample_value;
    int         errors;
    int         pending;

    // idle control: busy stretches vs calm stretches, none near the end
    bit         busy  = 1'b1;
    bit         quiet = 1'b0;
    int         sent  = 0;

    sync_framed_sample_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_in       (byte_in),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .kind          (kind),
        .channel_count (channel_count),
        .channel       (channel),
        .sample_value  (sample_value)
    );

    deframer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_in       (byte_in),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .kind          (kind),
        .channel_count (channel_count),
        .channel       (channel),
        .sample_value  (sample_value),
        .errors        (errors),
        .pending       (pending)
    );

    // Clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result-side stall bursts
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && busy && !quiet && $urandom_range(0, 3) == 0) begin
                sample_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                sample_stall <= 1'b0;
            end
        end
    end

    // Offer one byte, with an optional idle burst first; returns after acceptance
    task automatic push_byte(input logic [7:0] b);
        if (busy && !quiet && $urandom_range(0, 4) == 0) begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_in    <= b;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        sent++;
    endtask

    // One random frame: sync, header, sample pairs, with broken variants
    task automatic push_frame();
        int n;
        // noise ahead of the frame
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
        push_byte(sfsd_pkg::SYNC_BYTE);
        // broken sync: non-sync second byte
        if ($urandom_range(0, 9) == 0) begin
            push_byte(8'($urandom_range(0, 254)));
            return;
        end
        push_byte(sfsd_pkg::SYNC_BYTE);
        // header repeating the sync byte keeps the header slot open
        if ($urandom_range(0, 9) == 0)
            push_byte(sfsd_pkg::SYNC_BYTE);
        push_byte(8'($urandom_range(0, 254)));
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            // sync byte in the MSB slot drops back to the second sync byte
            if ($urandom_range(0, 19) == 0) begin
                push_byte(sfsd_pkg::SYNC_BYTE);
                return;
            end
            push_byte(8'($urandom_range(0, 254)));
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [7:0] directed[$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed stream: extreme fields, resync paths, false sync, sync header
        directed = {8'hFF, 8'hFF, 8'hF0,            // count 15, bank 0
                    8'h00, 8'h00,                   // all-zero sample
                    8'hFE, 8'hFF,                   // largest MSB, all-ones LSB
                    8'hFF,                          // sync in MSB slot
                    8'h00,                          // false second sync byte
                    8'hFF, 8'hFF, 8'hFF, 8'hEF,     // header FF held, then bank 15
                    8'h7C, 8'h00,                   // channel 511
                    8'h83, 8'hFF,                   // value 1023
                    8'hFF, 8'hFF, 8'h00,            // header zero
                    8'h55, 8'hAA};
        foreach (directed[i])
            push_byte(directed[i]);

        // random frames; calm and busy stretches, quiet at the end
        sent = 0;
        while (sent < 1250) begin
            busy  = ($urandom_range(0, 2) != 0);
            quiet = (sent > 1100);
            push_frame();
        end
        quiet = 1'b1;
        byte_valid <= 1'b0;
        @(posedge clk);

        // drain
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/sfsd_pkg.sv
sv/sfsd_decode.sv
sv/sfsd_out_reg.sv
sv/sync_framed_sample_deframer.sv
sv/sfsd_checker.sv
dv/deframer_checker.sv
dv/tb.sv
